/* design/ioplex_pkg.sv */
package ioplex_pkg;

    localparam int DEF_LINE_BITS = 16;
    localparam int DEF_COL_BITS  = 16;
    localparam int Q_DEPTH       = 4;
    localparam int VAL_BITS      = 63;
    localparam int WIDE_BITS     = 68;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_mark;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  op_code;
        logic [62:0] int_value;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] tok_len;
        logic [2:0]  err_code;
        logic        last;
    } t_out_item;

    // results of one item, handed from the core to the output queue
    typedef struct packed {
        logic [1:0]            cnt;
        t_out_item [1:0]       res;
    } t_push;

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_ZERO,
        M_NUMBER,
        M_OP,
        M_HALT,
        M_DONE
    } t_mode;

    typedef enum logic [1:0] {
        K_EOF = 2'd0,
        K_INT = 2'd1,
        K_OP  = 2'd2,
        K_ERR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        E_TAB      = 3'd0,
        E_BAD_CHAR = 3'd1,
        E_NO_DIGIT = 3'd2,
        E_LETTER   = 3'd3,
        E_OVERFLOW = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        OP_DSLASH = 4'd0,
        OP_DSTAR  = 4'd1,
        OP_SHL    = 4'd2,
        OP_SHR    = 4'd3,
        OP_PLUS   = 4'd4,
        OP_MINUS  = 4'd5,
        OP_STAR   = 4'd6,
        OP_SLASH  = 4'd7,
        OP_PCT    = 4'd8,
        OP_AMP    = 4'd9,
        OP_BAR    = 4'd10,
        OP_CARET  = 4'd11,
        OP_TILDE  = 4'd12,
        OP_LPAR   = 4'd13,
        OP_RPAR   = 4'd14
    } t_op;

    localparam logic [4:0] BASE_BIN = 5'd2;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // {valid, value} of c as a digit of the given base
    function automatic logic [4:0] digit_val(input logic [7:0] c, input logic [4:0] base);
        logic [7:0] raw;
        logic       ok;
        raw = 8'd0;
        ok  = 1'b0;
        if (c inside {[8'h30:8'h39]}) begin
            raw = c - 8'h30;
            ok  = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            raw = c - 8'h57;
            ok  = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            raw = c - 8'h37;
            ok  = 1'b1;
        end
        if (raw >= 8'(base)) begin
            ok = 1'b0;
        end
        return {ok, raw[3:0]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    // {valid, code} for the single-character operators
    function automatic logic [4:0] single_op(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            CH_PLUS:  r = {1'b1, OP_PLUS};
            CH_MINUS: r = {1'b1, OP_MINUS};
            CH_STAR:  r = {1'b1, OP_STAR};
            CH_SLASH: r = {1'b1, OP_SLASH};
            CH_PCT:   r = {1'b1, OP_PCT};
            CH_AMP:   r = {1'b1, OP_AMP};
            CH_BAR:   r = {1'b1, OP_BAR};
            CH_CARET: r = {1'b1, OP_CARET};
            CH_TILDE: r = {1'b1, OP_TILDE};
            CH_LPAR:  r = {1'b1, OP_LPAR};
            CH_RPAR:  r = {1'b1, OP_RPAR};
            default:  r = 5'd0;
        endcase
        return r;
    endfunction

    // accum times base by shifts and adds
    function automatic logic [WIDE_BITS-1:0] scale(input logic [VAL_BITS-1:0] acc,
                                                   input logic [4:0] base);
        logic [WIDE_BITS-1:0] w;
        logic [WIDE_BITS-1:0] r;
        w = WIDE_BITS'(acc);
        case (base)
            BASE_BIN: r = w << 1;
            BASE_OCT: r = w << 3;
            BASE_HEX: r = w << 4;
            default:  r = (w << 3) + (w << 1);
        endcase
        return r;
    endfunction

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_out_item mk_res(input logic [1:0] kind, input logic [3:0] op,
                                         input logic [62:0] val, input logic [31:0] line,
                                         input logic [31:0] col, input logic [15:0] len,
                                         input logic [2:0] err);
        t_out_item r;
        r.kind      = kind;
        r.op_code   = op;
        r.int_value = val;
        r.line_no   = clamp16(line);
        r.col_no    = clamp16(col);
        r.tok_len   = len;
        r.err_code  = err;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

/* design/ioplex_core.sv */
module ioplex_core #(
    parameter int LINE_BITS = ioplex_pkg::DEF_LINE_BITS,
    parameter int COL_BITS  = ioplex_pkg::DEF_COL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  ioplex_pkg::t_in_item i_item,
    output ioplex_pkg::t_push    o_push
);

    ioplex_pkg::t_mode    r_mode, n_mode;
    logic [7:0]           r_pend, n_pend;
    logic [4:0]           r_base, n_base;
    logic [62:0]          r_accum, n_accum;
    logic                 r_ovf, n_ovf;
    logic                 r_digit, n_digit;
    logic [COL_BITS-1:0]  r_start, n_start;
    logic [15:0]          r_len, n_len;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [COL_BITS-1:0]  r_col, n_col;

    ioplex_pkg::t_out_item [1:0] res;
    logic [1:0]                  cnt;

    always_comb begin
        logic [7:0]  c;
        logic        at_end;
        logic        fin;
        logic [4:0]  dv;
        logic [4:0]  so;
        logic [4:0]  pb;
        logic [67:0] scaled;
        logic [3:0]  code;
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_base  = r_base;
        n_accum = r_accum;
        n_ovf   = r_ovf;
        n_digit = r_digit;
        n_start = r_start;
        n_len   = r_len;
        n_line  = r_line;
        n_col   = r_col;
        res     = '0;
        cnt     = 2'd0;
        fin     = 1'b0;
        scaled  = '0;
        code    = ioplex_pkg::OP_DSLASH;
        c       = i_item.ch;
        at_end  = i_item.end_mark || (c == ioplex_pkg::CH_NUL);
        dv      = ioplex_pkg::digit_val(c, r_base);
        so      = ioplex_pkg::single_op(c);
        pb      = 5'd0;

        if (r_mode == ioplex_pkg::M_HALT || r_mode == ioplex_pkg::M_DONE) begin
            fin = 1'b1;
        end

        if (!fin && n_mode == ioplex_pkg::M_COMMENT) begin
            if (at_end || c == ioplex_pkg::CH_LF) begin
                n_mode = ioplex_pkg::M_IDLE;
            end else begin
                if (n_col != '1) n_col = n_col + 1'b1;
                fin = 1'b1;
            end
        end

        if (!fin && n_mode == ioplex_pkg::M_ZERO) begin
            if (!at_end) begin
                if (c == ioplex_pkg::CH_LX || c == ioplex_pkg::CH_UX) begin
                    pb = ioplex_pkg::BASE_HEX;
                end else if (c == ioplex_pkg::CH_LO || c == ioplex_pkg::CH_UO) begin
                    pb = ioplex_pkg::BASE_OCT;
                end else if (c == ioplex_pkg::CH_LB || c == ioplex_pkg::CH_UB) begin
                    pb = ioplex_pkg::BASE_BIN;
                end
            end
            n_mode = ioplex_pkg::M_NUMBER;
            if (pb != 5'd0) begin
                n_base  = pb;
                n_accum = '0;
                n_digit = 1'b0;
                n_len   = 16'd2;
                if (n_col != '1) n_col = n_col + 1'b1;
                fin = 1'b1;
            end
        end

        if (!fin && n_mode == ioplex_pkg::M_NUMBER) begin
            // base is still ten after a zero without prefix
            if (!at_end && (dv[4] || c == ioplex_pkg::CH_US)) begin
                if (dv[4]) begin
                    n_digit = 1'b1;
                    if (!n_ovf) begin
                        scaled = ioplex_pkg::scale(n_accum, n_base) + 68'(dv[3:0]);
                        if (scaled[67:63] != '0) n_ovf = 1'b1;
                        else n_accum = scaled[62:0];
                    end
                end
                if (n_len != 16'hFFFF) n_len = n_len + 16'd1;
                if (n_col != '1) n_col = n_col + 1'b1;
                fin = 1'b1;
            end else begin
                if (!n_digit) begin
                    res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH,
                        '0, 32'(n_line), 32'(n_start), (n_len != 16'd0) ? n_len : 16'd1,
                        ioplex_pkg::E_NO_DIGIT);
                    cnt = cnt + 2'd1;
                    n_mode = ioplex_pkg::M_HALT;
                    fin = 1'b1;
                end else if (!at_end && ioplex_pkg::is_alpha(c)) begin
                    res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH,
                        '0, 32'(n_line), 32'(n_start),
                        (n_len != 16'hFFFF) ? n_len + 16'd1 : n_len, ioplex_pkg::E_LETTER);
                    cnt = cnt + 2'd1;
                    n_mode = ioplex_pkg::M_HALT;
                    fin = 1'b1;
                end else if (n_ovf) begin
                    res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH,
                        '0, 32'(n_line), 32'(n_start), n_len, ioplex_pkg::E_OVERFLOW);
                    cnt = cnt + 2'd1;
                    n_mode = ioplex_pkg::M_HALT;
                    fin = 1'b1;
                end else begin
                    res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_INT, ioplex_pkg::OP_DSLASH,
                        n_accum, 32'(n_line), 32'(n_start), n_len, ioplex_pkg::E_TAB);
                    cnt = cnt + 2'd1;
                    n_mode = ioplex_pkg::M_IDLE;
                end
            end
        end

        if (!fin && n_mode == ioplex_pkg::M_OP) begin
            n_mode = ioplex_pkg::M_IDLE;
            if (!at_end && c == r_pend) begin
                case (r_pend)
                    ioplex_pkg::CH_SLASH: code = ioplex_pkg::OP_DSLASH;
                    ioplex_pkg::CH_STAR:  code = ioplex_pkg::OP_DSTAR;
                    ioplex_pkg::CH_LT:    code = ioplex_pkg::OP_SHL;
                    default:              code = ioplex_pkg::OP_SHR;
                endcase
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_OP, code, '0, 32'(n_line),
                    32'(n_start), 16'd2, ioplex_pkg::E_TAB);
                cnt = cnt + 2'd1;
                if (n_col != '1) n_col = n_col + 1'b1;
                fin = 1'b1;
            end else if (r_pend == ioplex_pkg::CH_LT || r_pend == ioplex_pkg::CH_GT) begin
                // lone shift character
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH, '0,
                    32'(n_line), 32'(n_start), 16'd1, ioplex_pkg::E_BAD_CHAR);
                cnt = cnt + 2'd1;
                n_mode = ioplex_pkg::M_HALT;
                fin = 1'b1;
            end else begin
                code = (r_pend == ioplex_pkg::CH_STAR) ? ioplex_pkg::OP_STAR
                                                       : ioplex_pkg::OP_SLASH;
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_OP, code, '0, 32'(n_line),
                    32'(n_start), 16'd1, ioplex_pkg::E_TAB);
                cnt = cnt + 2'd1;
            end
        end

        if (!fin) begin
            if (at_end) begin
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_EOF, ioplex_pkg::OP_DSLASH, '0,
                    32'(n_line), 32'(n_col), 16'd0, ioplex_pkg::E_TAB);
                cnt = cnt + 2'd1;
                n_mode = ioplex_pkg::M_DONE;
            end else if (c == ioplex_pkg::CH_LF) begin
                if (n_line != '1) n_line = n_line + 1'b1;
                n_col = COL_BITS'(1);
            end else if (c == ioplex_pkg::CH_SP) begin
                if (n_col != '1) n_col = n_col + 1'b1;
            end else if (c == ioplex_pkg::CH_TAB) begin
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH, '0,
                    32'(n_line), 32'(n_col), 16'd1, ioplex_pkg::E_TAB);
                cnt = cnt + 2'd1;
                n_mode = ioplex_pkg::M_HALT;
            end else if (c == ioplex_pkg::CH_HASH) begin
                n_mode = ioplex_pkg::M_COMMENT;
                if (n_col != '1) n_col = n_col + 1'b1;
            end else if (c inside {[8'h30:8'h39]}) begin
                n_start = n_col;
                n_len   = 16'd1;
                n_base  = ioplex_pkg::BASE_DEC;
                n_accum = 63'(c - ioplex_pkg::CH_ZERO);
                n_ovf   = 1'b0;
                n_digit = 1'b1;
                n_mode  = (c == ioplex_pkg::CH_ZERO) ? ioplex_pkg::M_ZERO
                                                     : ioplex_pkg::M_NUMBER;
                if (n_col != '1) n_col = n_col + 1'b1;
            end else if (c == ioplex_pkg::CH_SLASH || c == ioplex_pkg::CH_STAR ||
                         c == ioplex_pkg::CH_LT || c == ioplex_pkg::CH_GT) begin
                // may start a two-character operator, decide on the next byte
                n_pend  = c;
                n_start = n_col;
                n_mode  = ioplex_pkg::M_OP;
                if (n_col != '1) n_col = n_col + 1'b1;
            end else if (so[4]) begin
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_OP, so[3:0], '0,
                    32'(n_line), 32'(n_col), 16'd1, ioplex_pkg::E_TAB);
                cnt = cnt + 2'd1;
                if (n_col != '1) n_col = n_col + 1'b1;
            end else begin
                res[cnt[0]] = ioplex_pkg::mk_res(ioplex_pkg::K_ERR, ioplex_pkg::OP_DSLASH, '0,
                    32'(n_line), 32'(n_col), 16'd1, ioplex_pkg::E_BAD_CHAR);
                cnt = cnt + 2'd1;
                n_mode = ioplex_pkg::M_HALT;
            end
        end

        if (cnt != 2'd0) res[cnt[1]].last = 1'b1;
    end

    assign o_push.cnt = i_fire ? cnt : 2'd0;
    assign o_push.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ioplex_pkg::M_IDLE;
            r_pend  <= 8'd0;
            r_base  <= ioplex_pkg::BASE_DEC;
            r_accum <= '0;
            r_ovf   <= 1'b0;
            r_digit <= 1'b0;
            r_start <= COL_BITS'(1);
            r_len   <= 16'd0;
            r_line  <= LINE_BITS'(1);
            r_col   <= COL_BITS'(1);
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_base  <= n_base;
            r_accum <= n_accum;
            r_ovf   <= n_ovf;
            r_digit <= n_digit;
            r_start <= n_start;
            r_len   <= n_len;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == ioplex_pkg::M_HALT |=> r_mode == ioplex_pkg::M_HALT)
        else $error("halted lexer left halt without reset");

    a_quiet_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ioplex_pkg::M_HALT || r_mode == ioplex_pkg::M_DONE) |-> o_push.cnt == 2'd0)
        else $error("result produced after halt or end of source");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.cnt == 2'd2 |-> (o_push.res[1].last && !o_push.res[0].last))
        else $error("last flag not on the final result of an item");
`endif

endmodule

/* design/ioplex_outq.sv */
module ioplex_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ioplex_pkg::t_push     i_push,
    output logic                  o_room,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ioplex_pkg::t_out_item o_item
);

    localparam int DEPTH = ioplex_pkg::Q_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ioplex_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0]         r_rd, r_wr;
    logic [CW-1:0]         r_count, n_count;
    logic                  pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    // room for the worst case of two results per item
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign n_count = r_count + CW'(i_push.cnt) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res[0];
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push.res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push.cnt);
            r_rd    <= r_rd + PW'(pop);
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("output queue overfilled");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("results pushed without room");
`endif

endmodule

/* design/integer_and_operator_lexer.sv */
// Streaming lexer for integer literals and operators.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one source byte
// per item plus an end mark; a zero byte also ends the source.
// Output channel (o_out_valid / i_out_ready / o_out_item) carries tokens:
// kind, operator code, integer value, line, column, length, error code and a
// last flag on the final token caused by one input item.
// An accepted item enters an input register; from there the lexer core
// consumes it in one pass, once the output queue has room for two tokens, and
// writes its zero, one or two tokens into a four-entry output queue.
// One item is accepted per cycle while the queue holds at most two tokens, so
// the rate is one item per cycle until the output side falls behind; an item
// that yields two tokens is drained one token at a time.
// When the receiver stalls the queue fills and o_in_ready drops; nothing is lost.
// Reset (synchronous, active low) clears the queue, the input register and all
// lexer state: line 1, column 1. After an error token or the end-of-file token
// the block takes items but gives no further tokens until reset.
module integer_and_operator_lexer #(
    parameter int LINE_BITS = ioplex_pkg::DEF_LINE_BITS,
    parameter int COL_BITS  = ioplex_pkg::DEF_COL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ioplex_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ioplex_pkg::t_out_item o_out_item
);

    logic                 r_in_valid;
    ioplex_pkg::t_in_item r_in_item;
    logic                 room;
    logic                 fire;
    ioplex_pkg::t_push    push;

    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    ioplex_core #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    ioplex_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

/* tb/integer_and_operator_lexer_tb.sv */
`timescale 1ns / 1ps

module integer_and_operator_lexer_tb;

    import ioplex_pkg::*;

    localparam int          LINE_MAX     = (1 << DEF_LINE_BITS) - 1;
    localparam int          COL_MAX      = (1 << DEF_COL_BITS) - 1;
    localparam int          LEN_MAX      = 16'hFFFF;
    localparam logic [63:0] VAL_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          MAX_PRINTED  = 40;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam int          RUN_LIMIT_NS = 4_000_000;

    // fields that a token kind does not use read as zero
    localparam t_op  OP_NONE  = OP_DSLASH;
    localparam t_err ERR_NONE = E_TAB;

    typedef enum int {
        END_BY_MARK,
        END_BY_NUL,
        END_TAB,
        END_BAD_CHAR,
        END_LONE_ANGLE,
        END_NO_DIGITS,
        END_LETTER,
        END_OVERFLOW
    } t_ending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    integer_and_operator_lexer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // lexer state as the stream has left it
    t_mode       lx_mode       = M_IDLE;
    logic [7:0]  pend_ch       = 8'd0;
    logic [4:0]  num_base      = BASE_DEC;
    logic [63:0] acc_val       = 64'd0;
    logic        ovf_seen      = 1'b0;
    logic        dig_seen      = 1'b0;
    int          tok_start_col = 1;
    int          tok_length    = 0;
    int          line_cnt      = 1;
    int          col_cnt       = 1;

    t_out_item exp_tokens[$];
    int        err_count  = 0;
    int        sent_count = 0;
    int        tok_seen   = 0;
    logic      tx_burst   = 1'b0;
    logic      rx_burst   = 1'b0;
    int        rx_stall   = 0;
    int        rx_hold    = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[integer_and_operator_lexer] ERROR");
        $finish;
    end

    function automatic logic [15:0] sat16(input int v);
        return (v > LEN_MAX) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int digit_of(input logic [7:0] c, input logic [4:0] base);
        int d;
        d = -1;
        if (c >= CH_ZERO && c <= "9") begin
            d = c - CH_ZERO;
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 10;
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 10;
        end
        if (d >= int'(base)) begin
            d = -1;
        end
        return d;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic int op_for_char(input logic [7:0] c);
        case (c)
            CH_PLUS:  return OP_PLUS;
            CH_MINUS: return OP_MINUS;
            CH_STAR:  return OP_STAR;
            CH_SLASH: return OP_SLASH;
            CH_PCT:   return OP_PCT;
            CH_AMP:   return OP_AMP;
            CH_BAR:   return OP_BAR;
            CH_CARET: return OP_CARET;
            CH_TILDE: return OP_TILDE;
            CH_LPAR:  return OP_LPAR;
            CH_RPAR:  return OP_RPAR;
            default:  return -1;
        endcase
    endfunction

    // single-character operators in code order
    function automatic logic [7:0] op_char(input int i);
        case (i)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_PCT;
            5:       return CH_AMP;
            6:       return CH_BAR;
            7:       return CH_CARET;
            8:       return CH_TILDE;
            9:       return CH_LPAR;
            default: return CH_RPAR;
        endcase
    endfunction

    function automatic logic [7:0] hex_digit_char(input int v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic push_token(input t_kind k, input t_op op, input logic [62:0] v,
                              input int col, input int len, input t_err e);
        t_out_item t;
        t.kind      = k;
        t.op_code   = op;
        t.int_value = v;
        t.line_no   = sat16(line_cnt);
        t.col_no    = sat16(col);
        t.tok_len   = sat16(len);
        t.err_code  = e;
        t.last      = 1'b0;
        exp_tokens.push_back(t);
    endtask

    task automatic bump_col();
        if (col_cnt < COL_MAX) begin
            col_cnt++;
        end
    endtask

    task automatic push_digit(input int d);
        logic [63:0] b;
        b = 64'(num_base);
        dig_seen = 1'b1;
        if (!ovf_seen) begin
            if (acc_val > (VAL_LIMIT - 64'(d)) / b) begin
                ovf_seen = 1'b1;
            end else begin
                acc_val = acc_val * b + 64'(d);
            end
        end
    endtask

    task automatic idle_byte(input logic [7:0] c);
        int op;
        op = op_for_char(c);
        if (c == CH_LF) begin
            if (line_cnt < LINE_MAX) begin
                line_cnt++;
            end
            col_cnt = 1;
        end else if (c == CH_SP) begin
            bump_col();
        end else if (c == CH_TAB) begin
            push_token(K_ERR, OP_NONE, '0, col_cnt, 1, E_TAB);
            lx_mode = M_HALT;
        end else if (c == CH_HASH) begin
            lx_mode = M_COMMENT;
            bump_col();
        end else if (c >= CH_ZERO && c <= "9") begin
            tok_start_col = col_cnt;
            tok_length    = 1;
            num_base      = BASE_DEC;
            acc_val       = '0;
            ovf_seen      = 1'b0;
            dig_seen      = 1'b0;
            push_digit(c - CH_ZERO);
            lx_mode = (c == CH_ZERO) ? M_ZERO : M_NUMBER;
            bump_col();
        end else if (c == CH_SLASH || c == CH_STAR || c == CH_LT || c == CH_GT) begin
            // may pair with the next byte
            pend_ch       = c;
            tok_start_col = col_cnt;
            lx_mode       = M_OP;
            bump_col();
        end else if (op >= 0) begin
            push_token(K_OP, t_op'(op), '0, col_cnt, 1, ERR_NONE);
            bump_col();
        end else begin
            push_token(K_ERR, OP_NONE, '0, col_cnt, 1, E_BAD_CHAR);
            lx_mode = M_HALT;
        end
    endtask

    // tokens caused by one accepted item, appended to exp_tokens
    task automatic lex_step(input logic [7:0] c, input logic em);
        int          n0;
        int          d;
        logic        at_end;
        logic        done;
        logic [4:0]  b;
        logic [7:0]  p;
        t_op         code;
        t_out_item   t;
        n0     = exp_tokens.size();
        at_end = em || (c == CH_NUL);
        done   = 1'b0;
        if (lx_mode == M_HALT || lx_mode == M_DONE) begin
            return;
        end
        if (lx_mode == M_COMMENT) begin
            if (at_end || c == CH_LF) begin
                lx_mode = M_IDLE;
            end else begin
                bump_col();
                return;
            end
        end
        if (lx_mode == M_ZERO) begin
            b = '0;
            if (!at_end) begin
                if (c == CH_LX || c == CH_UX) begin
                    b = BASE_HEX;
                end else if (c == CH_LO || c == CH_UO) begin
                    b = BASE_OCT;
                end else if (c == CH_LB || c == CH_UB) begin
                    b = BASE_BIN;
                end
            end
            if (b != '0) begin
                num_base   = b;
                acc_val    = '0;
                dig_seen   = 1'b0;
                tok_length = 2;
                lx_mode    = M_NUMBER;
                bump_col();
                return;
            end
            lx_mode = M_NUMBER;
        end
        if (lx_mode == M_NUMBER) begin
            if (!at_end) begin
                d = digit_of(c, num_base);
                if (d >= 0 || c == CH_US) begin
                    if (d >= 0) begin
                        push_digit(d);
                    end
                    if (tok_length < LEN_MAX) begin
                        tok_length++;
                    end
                    bump_col();
                    return;
                end
            end
            // the number ends here; errors in priority order
            if (!dig_seen) begin
                push_token(K_ERR, OP_NONE, '0, tok_start_col,
                           (tok_length != 0) ? tok_length : 1, E_NO_DIGIT);
                lx_mode = M_HALT;
                done    = 1'b1;
            end else if (!at_end && is_letter(c)) begin
                push_token(K_ERR, OP_NONE, '0, tok_start_col, tok_length + 1, E_LETTER);
                lx_mode = M_HALT;
                done    = 1'b1;
            end else if (ovf_seen) begin
                push_token(K_ERR, OP_NONE, '0, tok_start_col, tok_length, E_OVERFLOW);
                lx_mode = M_HALT;
                done    = 1'b1;
            end else begin
                push_token(K_INT, OP_NONE, acc_val[62:0], tok_start_col, tok_length, ERR_NONE);
                lx_mode = M_IDLE;
            end
        end
        if (!done && lx_mode == M_OP) begin
            p       = pend_ch;
            lx_mode = M_IDLE;
            if (!at_end && c == p) begin
                if (p == CH_SLASH) begin
                    code = OP_DSLASH;
                end else if (p == CH_STAR) begin
                    code = OP_DSTAR;
                end else if (p == CH_LT) begin
                    code = OP_SHL;
                end else begin
                    code = OP_SHR;
                end
                push_token(K_OP, code, '0, tok_start_col, 2, ERR_NONE);
                bump_col();
                done = 1'b1;
            end else if (p == CH_LT || p == CH_GT) begin
                // lone angle bracket; the byte after it is dropped
                push_token(K_ERR, OP_NONE, '0, tok_start_col, 1, E_BAD_CHAR);
                lx_mode = M_HALT;
                done    = 1'b1;
            end else begin
                push_token(K_OP, (p == CH_STAR) ? OP_STAR : OP_SLASH, '0, tok_start_col, 1,
                           ERR_NONE);
            end
        end
        if (!done) begin
            if (at_end) begin
                push_token(K_EOF, OP_NONE, '0, col_cnt, 0, ERR_NONE);
                lx_mode = M_DONE;
            end else begin
                idle_byte(c);
            end
        end
        if (exp_tokens.size() > n0) begin
            t      = exp_tokens.pop_back();
            t.last = 1'b1;
            exp_tokens.push_back(t);
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic em);
        int       gap;
        t_in_item it;
        gap         = tx_burst ? 0 : $urandom_range(0, 7);
        it.ch       = c;
        it.end_mark = em;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        lex_step(c, em);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], 1'b0);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_tokens.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver: a per-token stall, plus a long hold when a test asks for it
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                i_out_ready <= 1'b0;
                rx_stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_tokens
        t_out_item got;
        t_out_item want;
        if (o_out_valid && i_out_ready) begin
            got = o_out_item;
            if ($urandom_range(0, 15) == 0) begin
                rx_burst = !rx_burst;
            end
            rx_stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (exp_tokens.size() == 0) begin
                flag_error($sformatf("token %0d arrived with none expected", tok_seen));
            end else begin
                want = exp_tokens.pop_front();
                if (got.kind != want.kind)
                    flag_error($sformatf("token %0d kind %0d, want %0d",
                                         tok_seen, got.kind, want.kind));
                if (got.op_code != want.op_code)
                    flag_error($sformatf("token %0d op_code %0d, want %0d",
                                         tok_seen, got.op_code, want.op_code));
                if (got.int_value != want.int_value)
                    flag_error($sformatf("token %0d int_value %0h, want %0h",
                                         tok_seen, got.int_value, want.int_value));
                if (got.line_no != want.line_no)
                    flag_error($sformatf("token %0d line_no %0d, want %0d",
                                         tok_seen, got.line_no, want.line_no));
                if (got.col_no != want.col_no)
                    flag_error($sformatf("token %0d col_no %0d, want %0d",
                                         tok_seen, got.col_no, want.col_no));
                if (got.tok_len != want.tok_len)
                    flag_error($sformatf("token %0d tok_len %0d, want %0d",
                                         tok_seen, got.tok_len, want.tok_len));
                if (got.err_code != want.err_code)
                    flag_error($sformatf("token %0d err_code %0d, want %0d",
                                         tok_seen, got.err_code, want.err_code));
                if (got.last != want.last)
                    flag_error($sformatf("token %0d last %0d, want %0d",
                                         tok_seen, got.last, want.last));
            end
            tok_seen++;
        end
    end

    task automatic test_operators();
        send_text("+-*/%&|^~() // ** << >> * / **/\n");
    endtask

    task automatic test_numbers();
        // zero, largest value, every prefix case, a digit outside its base
        send_text("0 0x7fffffffffffffff 0b1_01 0O17 0XaF 0B1 0o7 0b12 007 9_9 0x_1\n");
    endtask

    task automatic test_comments();
        send_text("# a # ( <\n  5 # x\n#\n3#q\n");
    endtask

    task automatic test_backpressure();
        rx_hold  = 60;
        tx_burst = 1'b1;
        send_text("+-+-+-+-12+3*4%5&6|7^8~(9)<<1>>2**3//4");
        tx_burst = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_stream();
        int         start;
        int         ndig;
        int         k;
        logic [4:0] num_radix;
        logic [7:0] c;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                tx_burst = !tx_burst;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            // 18 decimal digits never overflow
                            num_radix = BASE_DEC;
                            ndig      = $urandom_range(1, 18);
                        end
                        1: begin
                            num_radix = BASE_HEX;
                            ndig      = $urandom_range(1, 15);
                            send_byte(CH_ZERO, 1'b0);
                            send_byte($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
                        end
                        2: begin
                            num_radix = BASE_OCT;
                            ndig      = $urandom_range(1, 20);
                            send_byte(CH_ZERO, 1'b0);
                            send_byte($urandom_range(0, 1) ? CH_LO : CH_UO, 1'b0);
                        end
                        default: begin
                            num_radix = BASE_BIN;
                            ndig      = $urandom_range(1, 40);
                            send_byte(CH_ZERO, 1'b0);
                            send_byte($urandom_range(0, 1) ? CH_LB : CH_UB, 1'b0);
                        end
                    endcase
                    for (int i = 0; i < ndig; i++) begin
                        // a decimal literal cannot open with a separator
                        if ((i > 0 || num_radix != BASE_DEC) && $urandom_range(0, 4) == 0) begin
                            send_byte(CH_US, 1'b0);
                        end
                        send_byte(hex_digit_char($urandom_range(0, num_radix - 1)), 1'b0);
                    end
                    case ($urandom_range(0, 2))
                        0:       send_byte(CH_SP, 1'b0);
                        1:       send_byte(CH_LF, 1'b0);
                        default: send_byte(op_char($urandom_range(0, 10)), 1'b0);
                    endcase
                end
                4, 5, 6, 7: begin
                    k = $urandom_range(0, 14);
                    if (k < 4) begin
                        c = (k == 0) ? CH_SLASH : (k == 1) ? CH_STAR : (k == 2) ? CH_LT : CH_GT;
                        send_byte(c, 1'b0);
                        send_byte(c, 1'b0);
                    end else begin
                        send_byte(op_char(k - 4), 1'b0);
                    end
                    case ($urandom_range(0, 3))
                        0:       send_byte(CH_SP, 1'b0);
                        1:       send_byte(CH_LF, 1'b0);
                        default: ;
                    endcase
                end
                8: begin
                    send_byte(CH_HASH, 1'b0);
                    repeat ($urandom_range(0, 12)) begin
                        c = 8'($urandom_range(1, 255));
                        send_byte((c == CH_LF) ? CH_SP : c, 1'b0);
                    end
                    send_byte(CH_LF, 1'b0);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) send_byte(CH_SP, 1'b0);
                end
            endcase
        end
        tx_burst = 1'b0;
        wait_drained();
    endtask

    task automatic test_termination();
        t_ending    ending;
        logic [7:0] c;
        ending = t_ending'($urandom_range(0, 7));
        send_text("5 ");
        case (ending)
            END_BY_MARK: begin
                send_text("42");
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_BY_NUL: begin
                send_text("*");
                send_byte(CH_NUL, 1'b0);
            end
            END_TAB: begin
                send_byte(CH_TAB, 1'b0);
            end
            END_BAD_CHAR: begin
                do begin
                    c = 8'($urandom_range(1, 255));
                end while ((c >= CH_ZERO && c <= "9") || c == CH_SP || c == CH_LF
                           || c == CH_TAB || c == CH_HASH || c == CH_LT || c == CH_GT
                           || op_for_char(c) >= 0);
                send_byte(c, 1'b0);
            end
            END_LONE_ANGLE: begin
                send_text($urandom_range(0, 1) ? "<x" : ">1");
            end
            END_NO_DIGITS: begin
                send_text("0x_ ");
            end
            END_LETTER: begin
                send_text("12z");
            end
            default: begin
                send_text("0xffff_ffff_ffff_ffff ");
            end
        endcase
        // the block is halted or at end of source now; these give nothing
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : run_tests
        int n;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_operators();
        test_numbers();
        test_comments();
        test_backpressure();
        test_random_stream();
        test_termination();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        n = 0;
        while (exp_tokens.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
        if (exp_tokens.size() != 0) begin
            flag_error($sformatf("%0d expected tokens never arrived", exp_tokens.size()));
        end
        if (err_count == 0) begin
            $display("[integer_and_operator_lexer] OK");
        end else begin
            $display("[integer_and_operator_lexer] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ioplex_pkg.sv
design/ioplex_core.sv
design/ioplex_outq.sv
design/integer_and_operator_lexer.sv
tb/integer_and_operator_lexer_tb.sv
